[hw/rtl/quadratic_bisection_root_top_macros.svh]
// Assertion macros for the bisection root finder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef QUADRATIC_BISECTION_ROOT_TOP_MACROS_SVH
`define QUADRATIC_BISECTION_ROOT_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define QBR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qbr assertion failed: implication");

`define QBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qbr assertion failed: next-cycle implication");

`define QBR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("qbr assertion failed: forbidden condition");

`else

`define QBR_ASSERT_IMP(lbl, ante, cons)
`define QBR_ASSERT_NEXT(lbl, ante, cons)
`define QBR_ASSERT_NEVER(lbl, expr)

`endif

`endif

[hw/rtl/qbr_pkg.sv]
`default_nettype none

package qbr_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_STEPS_DEF = 40;

  // Register reset values, Q16.16.
  localparam longint LOWER_RESET = -45875;
  localparam longint UPPER_RESET = 98304;
  localparam longint TOL_RESET   = 66;

  typedef enum logic [1:0] {
    REG_LOWER = 2'd0,
    REG_UPPER = 2'd1,
    REG_TOL   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_NO_PREC   = 2'd2
  } status_t;

  // Which point the shared evaluator is working on.
  typedef enum logic [1:0] {
    PH_LOW   = 2'd0,
    PH_HIGH  = 2'd1,
    PH_MID   = 2'd2,
    PH_FINAL = 2'd3
  } phase_t;

endpackage

`default_nettype wire

[hw/rtl/quadratic_bisection_root_top.sv]
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    coef_square, coef_linear, coef_const
// out       source     out_valid/out_ready  root, status
// cfg       sink       cfg_write            cfg_index, cfg_data
//
// An item runs at most MAX_STEPS bisection steps, or none without a sign change.
// Each evaluation of f steps through S_MULA, S_ADDB, S_MULLO, S_MULHI, S_ACC
// and S_DECIDE on the one shared 33x32 multiplier and the wide accumulator,
// and each bisection step adds S_CHECK for the interval check. A new item is
// taken only while the sequencer is idle, but a finished result may wait in
// the output register meanwhile. Reset is synchronous and clears the
// sequencer, the valid flag, the interval registers and the pending result.
`default_nettype none

`include "quadratic_bisection_root_top_macros.svh"

module quadratic_bisection_root_top
  import qbr_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [WORD_BITS-1:0] coef_square,
  input  wire logic signed [WORD_BITS-1:0] coef_linear,
  input  wire logic signed [WORD_BITS-1:0] coef_const,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      root,
  output logic [1:0]                       status,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [WORD_BITS-1:0]        cfg_data
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  // Width of a*x + b*2^F, and of the operand the multiplier takes from it.
  localparam int SW  = ((2 * W > W + F) ? 2 * W : W + F) + 1;
  localparam int MA  = SW - W;
  localparam int PW  = MA + W;
  // Width that holds f scaled by 2^(2F) exactly.
  localparam int FM0 = (3 * W > 2 * W + F) ? 3 * W : 2 * W + F;
  localparam int FW  = ((FM0 > W + 2 * F) ? FM0 : W + 2 * F) + 2;
  localparam int SCW = $clog2(MAX_STEPS + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MULA   = 9'b000000010,
    S_ADDB   = 9'b000000100,
    S_MULLO  = 9'b000001000,
    S_MULHI  = 9'b000010000,
    S_ACC    = 9'b000100000,
    S_DECIDE = 9'b001000000,
    S_CHECK  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;
  phase_t phase;

  logic signed [W-1:0] lower_bound;
  logic signed [W-1:0] upper_bound;
  logic [W-2:0]        tolerance;

  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;
  logic signed [W-1:0] low_end;
  logic signed [W-1:0] high_end;
  logic signed [W-1:0] x;
  logic [SCW-1:0]      step_count;
  logic                sl_neg;
  logic                sl_nz;

  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] s_reg;
  logic signed [FW-1:0] acc;

  logic signed [W-1:0] res_root;
  status_t             res_status;

  // Shared multiplier.
  logic signed [MA-1:0] mul_a;
  logic signed [PW-1:0] mul_out;

  always_comb begin
    case (state)
      S_MULA:  mul_a = MA'(coef_a);
      S_MULLO: mul_a = $signed({{(MA - W){1'b0}}, s_reg[W-1:0]});
      S_MULHI: mul_a = s_reg[SW-1:W];
      default: mul_a = MA'(coef_a);
    endcase
  end

  assign mul_out = PW'(mul_a) * PW'(x);

  // Residual test |f| < eps, with f held at scale 2^(2F).
  logic signed [FW-1:0] thr;
  logic                 f_below;
  logic                 f_neg;
  logic                 f_nz;

  assign thr     = $signed({{(FW - W + 1){1'b0}}, tolerance} << (2 * F));
  assign f_below = (acc < thr) && (acc > -thr);
  assign f_neg   = acc[FW-1];
  assign f_nz    = |acc;

  // Interval width test and midpoint, rounded toward minus infinity.
  logic signed [W+1:0] diff;
  logic signed [W+1:0] two_eps;
  logic signed [W:0]   mid_sum;
  logic signed [W-1:0] mid;
  logic                keep_going;

  assign diff       = (W + 2)'(high_end) - (W + 2)'(low_end);
  assign two_eps    = $signed({2'b00, tolerance, 1'b0});
  assign mid_sum    = (W + 1)'(low_end) + (W + 1)'(high_end);
  assign mid        = mid_sum[W:1];
  assign keep_going = (diff > two_eps) && (step_count < SCW'(MAX_STEPS));

  assign in_ready = (state == S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= W'(LOWER_RESET);
      upper_bound <= W'(UPPER_RESET);
      tolerance   <= (W - 1)'(TOL_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOWER: lower_bound <= cfg_data;
        REG_UPPER: upper_bound <= cfg_data;
        REG_TOL:   tolerance   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // Datapath registers of the evaluator.
  always_ff @(posedge clk) begin
    case (state)
      S_MULA:  prod  <= mul_out;
      S_ADDB:  s_reg <= prod + (SW'(coef_b) <<< F);
      S_MULLO: prod  <= mul_out;
      S_MULHI: begin
        prod <= mul_out;
        acc  <= FW'(prod) + (FW'(coef_c) <<< (2 * F));
      end
      S_ACC:   acc   <= acc + (FW'(prod) <<< W);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      root   <= res_root;
      status <= res_status;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_LOW;
      out_valid  <= 1'b0;
      step_count <= '0;
      low_end    <= '0;
      high_end   <= '0;
      x          <= '0;
      sl_neg     <= 1'b0;
      sl_nz      <= 1'b0;
      res_root   <= '0;
      res_status <= ST_FOUND;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            coef_a     <= coef_square;
            coef_b     <= coef_linear;
            coef_c     <= coef_const;
            low_end    <= lower_bound;
            high_end   <= upper_bound;
            x          <= lower_bound;
            step_count <= '0;
            phase      <= PH_LOW;
            state      <= S_MULA;
          end
        end
        S_MULA:  state <= S_ADDB;
        S_ADDB:  state <= S_MULLO;
        S_MULLO: state <= S_MULHI;
        S_MULHI: state <= S_ACC;
        S_ACC:   state <= S_DECIDE;
        S_DECIDE: begin
          case (phase)
            PH_LOW: begin
              sl_neg <= f_neg;
              sl_nz  <= f_nz;
              x      <= high_end;
              phase  <= PH_HIGH;
              state  <= S_MULA;
            end
            PH_HIGH: begin
              // Both ends nonzero with the same sign: no bracket.
              if (sl_nz && f_nz && (sl_neg == f_neg)) begin
                res_root   <= '0;
                res_status <= ST_NO_CHANGE;
                state      <= S_DONE;
              end else begin
                state <= S_CHECK;
              end
            end
            PH_MID: begin
              step_count <= step_count + 1'b1;
              if (f_below) begin
                res_root   <= x;
                res_status <= ST_FOUND;
                state      <= S_DONE;
              end else begin
                if (sl_nz && f_nz && (sl_neg != f_neg)) begin
                  high_end <= x;
                end else begin
                  low_end <= x;
                  sl_neg  <= f_neg;
                  sl_nz   <= f_nz;
                end
                state <= S_CHECK;
              end
            end
            PH_FINAL: begin
              res_root   <= f_below ? x : '0;
              res_status <= f_below ? ST_FOUND : ST_NO_PREC;
              state      <= S_DONE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CHECK: begin
          x     <= mid;
          phase <= keep_going ? PH_MID : PH_FINAL;
          state <= S_MULA;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `QBR_ASSERT_NEVER(a_step_limit, step_count > SCW'(MAX_STEPS))
  `QBR_ASSERT_IMP(a_root_zero, out_valid && (status != ST_FOUND), root == '0)
  `QBR_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
